/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the RTL; they compile to nothing under synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

/* hw/rtl/mbr_pkg.sv */
// Types, codes and default sizes for the mailbox packet router.
package mbr_pkg;

    localparam int SLOTS_DEF       = 8;
    localparam int RING_DEPTH_DEF  = 8;
    localparam int PAYLOAD_MAX_DEF = 32;
    localparam int HEADER_BYTES    = 4;
    localparam int PID_W           = 15;
    localparam int LEN_W           = 6;

    localparam logic ACT_SEND    = 1'b0;
    localparam logic ACT_RECEIVE = 1'b1;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_NO_RECEIVER = 3'd1;
    localparam logic [2:0] ST_FULL        = 3'd2;
    localparam logic [2:0] ST_NO_FREE     = 3'd3;
    localparam logic [2:0] ST_EMPTY       = 3'd4;
    localparam logic [2:0] ST_SHORT       = 3'd5;

    localparam logic [1:0] KIND_ACK     = 2'd0;
    localparam logic [1:0] KIND_HEADER  = 2'd1;
    localparam logic [1:0] KIND_PAYLOAD = 2'd2;

    typedef struct packed {
        logic             action;
        logic [PID_W-1:0] own_pid;
        logic [PID_W-1:0] dest_pid;
        logic [7:0]       data_byte;
        logic             has_byte;
        logic             last_byte;
        logic [7:0]       read_limit;
    } cmd_t;

    typedef struct packed {
        logic [2:0]       status;
        logic [1:0]       kind;
        logic [PID_W-1:0] pid_value;
        logic [7:0]       out_byte;
        logic [LEN_W-1:0] length;
        logic             last;
    } res_t;

endpackage

/* hw/rtl/pid_mailbox_packet_router.sv */
// Mailbox packet router: per-receiver packet rings addressed by process id.
`include "assert_macros.svh"

// A word is accepted when start is high and busy is low. Each result is marked by
// a one-cycle strobe, and the receiver cannot stall them. The owner table is
// searched one slot per cycle through a single comparator; busy stays high through
// SCAN over every slot, DECIDE and S_BYTE on the first word of a send packet, and
// through SCAN and DECIDE on a receive that ends in an error status. A later word
// of a send packet skips the search and goes to S_BYTE. A receive that delivers a
// packet runs SCAN, DECIDE, R_LEN and R_HDR up to its header, then R_RD and R_OUT
// for each payload byte, set by the registered read ports of the packet memories.
module pid_mailbox_packet_router #(
    parameter int SLOTS       = mbr_pkg::SLOTS_DEF,
    parameter int RING_DEPTH  = mbr_pkg::RING_DEPTH_DEF,
    parameter int PAYLOAD_MAX = mbr_pkg::PAYLOAD_MAX_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  mbr_pkg::cmd_t cmd,
    output logic          busy,
    output logic          strobe,
    output mbr_pkg::res_t result
);
    import mbr_pkg::*;

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int RING_W = $clog2(RING_DEPTH);
    localparam int CNT_W  = $clog2(RING_DEPTH + 1);
    localparam int ENT_N  = SLOTS * RING_DEPTH;
    localparam int ENT_W  = $clog2(ENT_N);
    localparam int BYTE_N = ENT_N * PAYLOAD_MAX;
    localparam int BYTE_W = $clog2(BYTE_N);

    typedef enum logic [2:0] {
        IDLE, SCAN, DECIDE, S_BYTE, R_LEN, R_HDR, R_RD, R_OUT
    } state_t;

    state_t            state_reg;
    cmd_t              cmd_reg;
    logic              strobe_reg;
    res_t              result_reg;
    logic [PID_W-1:0]  owner_reg [SLOTS];
    logic [RING_W-1:0] head_reg  [SLOTS];
    logic [RING_W-1:0] tail_reg  [SLOTS];
    logic [CNT_W-1:0]  count_reg [SLOTS];
    logic              send_active_reg;
    logic [SLOT_W-1:0] send_slot_reg;
    logic [2:0]        send_error_reg;
    logic [LEN_W-1:0]  send_fill_reg;
    logic [SLOT_W-1:0] scan_idx_reg;
    logic              found_reg;
    logic [SLOT_W-1:0] found_idx_reg;
    logic              free_found_reg;
    logic [SLOT_W-1:0] free_idx_reg;
    logic [SLOT_W-1:0] rslot_reg;
    logic [ENT_W-1:0]  rd_ent_reg;
    logic [BYTE_W-1:0] byte_addr_reg;
    logic [LEN_W-1:0]  byte_cnt_reg;
    logic [LEN_W-1:0]  out_len_reg;

    logic [7:0]        byte_mem   [BYTE_N];
    logic [LEN_W-1:0]  length_mem [ENT_N];
    logic [PID_W-1:0]  sender_mem [ENT_N];
    logic [7:0]        byte_q;
    logic [LEN_W-1:0]  length_q;
    logic [PID_W-1:0]  sender_q;

    logic [PID_W-1:0]  scan_pid;
    logic [ENT_W-1:0]  send_ent;
    logic [ENT_W-1:0]  start_ent;
    logic              byte_we;
    logic [BYTE_W-1:0] byte_waddr;
    logic              length_we;
    logic              sender_we;
    logic [LEN_W-1:0]  fill_next;
    logic              send_ok_start;
    logic [SLOT_W-1:0] rslot;
    logic              claim;
    logic [CNT_W-1:0]  rcount;
    logic [7:0]        lim_avail;
    logic [LEN_W-1:0]  stored_len;
    logic [LEN_W-1:0]  out_len;
    logic              payload_err;

    function automatic res_t make_res(logic [2:0] st, logic [1:0] kd, logic [PID_W-1:0] pid,
                                      logic [7:0] b, logic [LEN_W-1:0] len, logic lst);
        res_t r;
        r.status    = st;
        r.kind      = kd;
        r.pid_value = pid;
        r.out_byte  = b;
        r.length    = len;
        r.last      = lst;
        return r;
    endfunction

    assign busy   = (state_reg != IDLE);
    assign strobe = strobe_reg;
    assign result = result_reg;

    assign scan_pid = (cmd_reg.action == ACT_SEND) ? cmd_reg.dest_pid : cmd_reg.own_pid;

    assign send_ent = ENT_W'(ENT_W'(send_slot_reg) * ENT_W'(RING_DEPTH))
                    + ENT_W'(tail_reg[send_slot_reg]);
    assign start_ent = ENT_W'(ENT_W'(found_idx_reg) * ENT_W'(RING_DEPTH))
                     + ENT_W'(tail_reg[found_idx_reg]);

    assign send_ok_start = found_reg && (count_reg[found_idx_reg] < CNT_W'(RING_DEPTH));
    assign sender_we = (state_reg == DECIDE) && (cmd_reg.action == ACT_SEND) && send_ok_start;

    assign byte_we = (state_reg == S_BYTE) && (send_error_reg == ST_OK) && cmd_reg.has_byte
                   && (send_fill_reg < LEN_W'(PAYLOAD_MAX));
    assign byte_waddr = BYTE_W'(BYTE_W'(send_ent) * BYTE_W'(PAYLOAD_MAX))
                      + BYTE_W'(send_fill_reg);
    assign fill_next = byte_we ? (send_fill_reg + LEN_W'(1)) : send_fill_reg;
    assign length_we = (state_reg == S_BYTE) && (send_error_reg == ST_OK) && cmd_reg.last_byte;

    assign claim  = !found_reg && free_found_reg && (cmd_reg.own_pid != '0);
    assign rslot  = found_reg ? found_idx_reg : free_idx_reg;
    assign rcount = claim ? '0 : count_reg[rslot];

    assign lim_avail  = cmd_reg.read_limit - 8'(HEADER_BYTES);
    assign stored_len = (length_q > LEN_W'(PAYLOAD_MAX)) ? LEN_W'(PAYLOAD_MAX) : length_q;
    assign out_len    = ({2'b00, stored_len} > lim_avail) ? lim_avail[LEN_W-1:0] : stored_len;

    assign payload_err = strobe && (result.kind == KIND_PAYLOAD) && (result.status != ST_OK);

    always_ff @(posedge clk)
    begin
        if (byte_we)
        begin
            byte_mem[byte_waddr] <= cmd_reg.data_byte;
        end
        byte_q <= byte_mem[byte_addr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (length_we)
        begin
            length_mem[send_ent] <= fill_next;
        end
        if (sender_we)
        begin
            sender_mem[start_ent] <= cmd_reg.own_pid;
        end
        length_q <= length_mem[rd_ent_reg];
        sender_q <= sender_mem[rd_ent_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= IDLE;
            cmd_reg         <= '0;
            strobe_reg      <= 1'b0;
            result_reg      <= '0;
            send_active_reg <= 1'b0;
            send_slot_reg   <= '0;
            send_error_reg  <= ST_OK;
            send_fill_reg   <= '0;
            scan_idx_reg    <= '0;
            found_reg       <= 1'b0;
            found_idx_reg   <= '0;
            free_found_reg  <= 1'b0;
            free_idx_reg    <= '0;
            rslot_reg       <= '0;
            byte_addr_reg   <= '0;
            byte_cnt_reg    <= '0;
            out_len_reg     <= '0;
            rd_ent_reg      <= '0;
            for (int i = 0; i < SLOTS; i++)
            begin
                owner_reg[i] <= '0;
                head_reg[i]  <= '0;
                tail_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
        end
        else
        begin
            unique case (state_reg)
                IDLE:
                begin
                    strobe_reg <= 1'b0;
                    if (start)
                    begin
                        cmd_reg        <= cmd;
                        scan_idx_reg   <= '0;
                        found_reg      <= 1'b0;
                        free_found_reg <= 1'b0;
                        if (cmd.action == ACT_SEND && send_active_reg)
                        begin
                            state_reg <= S_BYTE;
                        end
                        else
                        begin
                            state_reg <= SCAN;
                        end
                    end
                end
                SCAN:
                begin
                    strobe_reg <= 1'b0;
                    if (!found_reg && scan_pid != '0 && owner_reg[scan_idx_reg] == scan_pid)
                    begin
                        found_reg     <= 1'b1;
                        found_idx_reg <= scan_idx_reg;
                    end
                    if (!free_found_reg && owner_reg[scan_idx_reg] == '0)
                    begin
                        free_found_reg <= 1'b1;
                        free_idx_reg   <= scan_idx_reg;
                    end
                    if (scan_idx_reg == SLOT_W'(SLOTS - 1))
                    begin
                        state_reg <= DECIDE;
                    end
                    else
                    begin
                        scan_idx_reg <= scan_idx_reg + SLOT_W'(1);
                    end
                end
                DECIDE:
                begin
                    if (cmd_reg.action == ACT_SEND)
                    begin
                        send_active_reg <= 1'b1;
                        send_fill_reg   <= '0;
                        state_reg       <= S_BYTE;
                        if (!found_reg)
                        begin
                            send_error_reg <= ST_NO_RECEIVER;
                            send_slot_reg  <= '0;
                            strobe_reg     <= 1'b1;
                            result_reg     <= make_res(ST_NO_RECEIVER, KIND_ACK, '0, '0, '0, 1'b1);
                        end
                        else if (!send_ok_start)
                        begin
                            send_error_reg <= ST_FULL;
                            send_slot_reg  <= '0;
                            strobe_reg     <= 1'b1;
                            result_reg     <= make_res(ST_FULL, KIND_ACK, '0, '0, '0, 1'b1);
                        end
                        else
                        begin
                            send_error_reg <= ST_OK;
                            send_slot_reg  <= found_idx_reg;
                            strobe_reg     <= 1'b0;
                        end
                    end
                    else
                    begin
                        rslot_reg <= rslot;
                        if (claim)
                        begin
                            owner_reg[rslot] <= cmd_reg.own_pid;
                            head_reg[rslot]  <= '0;
                            tail_reg[rslot]  <= '0;
                            count_reg[rslot] <= '0;
                        end
                        if (!found_reg && !claim)
                        begin
                            strobe_reg <= 1'b1;
                            result_reg <= make_res(ST_NO_FREE, KIND_HEADER, '0, '0, '0, 1'b1);
                            state_reg  <= IDLE;
                        end
                        else if (rcount == '0)
                        begin
                            strobe_reg <= 1'b1;
                            result_reg <= make_res(ST_EMPTY, KIND_HEADER, '0, '0, '0, 1'b1);
                            state_reg  <= IDLE;
                        end
                        else if (cmd_reg.read_limit < 8'(HEADER_BYTES))
                        begin
                            strobe_reg <= 1'b1;
                            result_reg <= make_res(ST_SHORT, KIND_HEADER, '0, '0, '0, 1'b1);
                            state_reg  <= IDLE;
                        end
                        else
                        begin
                            strobe_reg <= 1'b0;
                            rd_ent_reg <= ENT_W'(ENT_W'(rslot) * ENT_W'(RING_DEPTH))
                                        + ENT_W'(head_reg[rslot]);
                            state_reg  <= R_LEN;
                        end
                    end
                end
                S_BYTE:
                begin
                    state_reg  <= IDLE;
                    strobe_reg <= (send_error_reg == ST_OK) && cmd_reg.last_byte;
                    if (send_error_reg == ST_OK && cmd_reg.last_byte)
                    begin
                        tail_reg[send_slot_reg]  <= (tail_reg[send_slot_reg]
                            == RING_W'(RING_DEPTH - 1)) ? '0
                            : tail_reg[send_slot_reg] + RING_W'(1);
                        count_reg[send_slot_reg] <= count_reg[send_slot_reg] + CNT_W'(1);
                        result_reg <= make_res(ST_OK, KIND_ACK, '0, '0, fill_next, 1'b1);
                    end
                    if (cmd_reg.last_byte)
                    begin
                        send_active_reg <= 1'b0;
                        send_error_reg  <= ST_OK;
                        send_fill_reg   <= '0;
                        send_slot_reg   <= '0;
                    end
                    else if (send_error_reg == ST_OK)
                    begin
                        send_fill_reg <= fill_next;
                    end
                end
                R_LEN:
                begin
                    strobe_reg <= 1'b0;
                    state_reg  <= R_HDR;
                end
                R_HDR:
                begin
                    strobe_reg <= 1'b1;
                    result_reg <= make_res(ST_OK, KIND_HEADER, sender_q, '0, out_len,
                                           out_len == '0);
                    head_reg[rslot_reg]  <= (head_reg[rslot_reg] == RING_W'(RING_DEPTH - 1))
                                          ? '0 : head_reg[rslot_reg] + RING_W'(1);
                    count_reg[rslot_reg] <= count_reg[rslot_reg] - CNT_W'(1);
                    byte_addr_reg <= BYTE_W'(BYTE_W'(rd_ent_reg) * BYTE_W'(PAYLOAD_MAX));
                    byte_cnt_reg  <= '0;
                    out_len_reg   <= out_len;
                    state_reg     <= (out_len == '0) ? IDLE : R_RD;
                end
                R_RD:
                begin
                    strobe_reg <= 1'b0;
                    state_reg  <= R_OUT;
                end
                R_OUT:
                begin
                    strobe_reg <= 1'b1;
                    result_reg <= make_res(ST_OK, KIND_PAYLOAD, '0, byte_q, '0,
                                           (byte_cnt_reg + LEN_W'(1)) == out_len_reg);
                    byte_addr_reg <= byte_addr_reg + BYTE_W'(1);
                    byte_cnt_reg  <= byte_cnt_reg + LEN_W'(1);
                    state_reg     <= ((byte_cnt_reg + LEN_W'(1)) == out_len_reg) ? IDLE : R_RD;
                end
                default:
                begin
                    strobe_reg <= 1'b0;
                    state_reg  <= IDLE;
                end
            endcase
        end
    end

    `ASSERT_CLK(a_strobe_while_busy, clk, rst_n, strobe |-> $past(busy), "result outside a word")
    `ASSERT_CLK(a_start_takes, clk, rst_n, (start && !busy) |=> busy, "accepted word not taken")
    `ASSERT_NEVER(a_fill_bound, clk, rst_n, send_fill_reg > LEN_W'(PAYLOAD_MAX), "fill overrun")
    `ASSERT_NEVER(a_payload_ok, clk, rst_n, payload_err, "payload with error status")

endmodule

/* tb/pid_mailbox_packet_router_tb.sv */
// Testbench for the mailbox packet router: directed and random words checked against a predictor.
module pid_mailbox_packet_router_tb;
    import mbr_pkg::*;

    localparam int NSLOT = 8;
    localparam int NRING = 8;
    localparam int PMAX = 32;
    localparam int STALL_LIMIT = 4000;

    logic clk;
    logic rst_n;
    logic start;
    cmd_t cmd;
    logic busy;
    logic strobe;
    res_t result;

    pid_mailbox_packet_router dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .cmd(cmd),
        .busy(busy),
        .strobe(strobe),
        .result(result)
    );

    logic [PID_W-1:0] owner_tab [NSLOT];
    int unsigned head_tab [NSLOT];
    int unsigned tail_tab [NSLOT];
    int unsigned count_tab [NSLOT];
    logic [7:0] byte_mem [NSLOT*NRING*PMAX];
    int unsigned len_mem [NSLOT*NRING];
    logic [PID_W-1:0] sender_mem [NSLOT*NRING];
    bit pkt_open;
    int unsigned pkt_slot;
    logic [2:0] pkt_err;
    int unsigned pkt_fill;

    res_t expected_results[$];
    int mismatches;
    int idle_pct;
    int quiet_cycles;
    bit timed_out;

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function automatic res_t make_res(logic [2:0] st, logic [1:0] k, logic [PID_W-1:0] p,
                                      logic [7:0] b, int unsigned len, logic l);
        res_t r;
        r.status = st;
        r.kind = k;
        r.pid_value = p;
        r.out_byte = b;
        r.length = len[LEN_W-1:0];
        r.last = l;
        return r;
    endfunction

    function automatic cmd_t rand_cmd();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return cmd_t'(raw[$bits(cmd_t)-1:0]);
    endfunction

    function automatic int find_mailbox(logic [PID_W-1:0] pid);
        if (pid == '0)
            return -1;
        for (int i = 0; i < NSLOT; i++)
            if (owner_tab[i] == pid)
                return i;
        return -1;
    endfunction

    task automatic route_word(cmd_t c);
        int s;
        int unsigned ent;
        int unsigned n;
        int unsigned lim;
        if (c.action == ACT_SEND)
        begin
            if (!pkt_open)
            begin
                s = find_mailbox(c.dest_pid);
                pkt_open = 1'b1;
                pkt_fill = 0;
                pkt_slot = 0;
                if (s < 0)
                    pkt_err = ST_NO_RECEIVER;
                else if (count_tab[s] >= NRING)
                    pkt_err = ST_FULL;
                else
                begin
                    pkt_err = ST_OK;
                    pkt_slot = s;
                    sender_mem[s*NRING + tail_tab[s]] = c.own_pid;
                end
                if (pkt_err != ST_OK)
                    expected_results.push_back(make_res(pkt_err, KIND_ACK, '0, '0, 0, 1'b1));
            end
            if (pkt_err == ST_OK)
            begin
                ent = pkt_slot*NRING + tail_tab[pkt_slot];
                if (c.has_byte && pkt_fill < PMAX)
                begin
                    byte_mem[ent*PMAX + pkt_fill] = c.data_byte;
                    pkt_fill++;
                end
                if (c.last_byte)
                begin
                    len_mem[ent] = pkt_fill;
                    tail_tab[pkt_slot] = (tail_tab[pkt_slot] + 1) % NRING;
                    count_tab[pkt_slot]++;
                    expected_results.push_back(make_res(ST_OK, KIND_ACK, '0, '0, pkt_fill, 1'b1));
                end
            end
            if (c.last_byte)
            begin
                pkt_open = 1'b0;
                pkt_err = ST_OK;
                pkt_fill = 0;
                pkt_slot = 0;
            end
        end
        else
        begin
            s = find_mailbox(c.own_pid);
            lim = c.read_limit;
            if (s < 0 && c.own_pid != '0)
            begin
                for (int i = 0; i < NSLOT; i++)
                begin
                    if (owner_tab[i] == '0)
                    begin
                        s = i;
                        owner_tab[i] = c.own_pid;
                        head_tab[i] = 0;
                        tail_tab[i] = 0;
                        count_tab[i] = 0;
                        break;
                    end
                end
            end
            if (s < 0)
                expected_results.push_back(make_res(ST_NO_FREE, KIND_HEADER, '0, '0, 0, 1'b1));
            else if (count_tab[s] == 0)
                expected_results.push_back(make_res(ST_EMPTY, KIND_HEADER, '0, '0, 0, 1'b1));
            else if (lim < HEADER_BYTES)
                expected_results.push_back(make_res(ST_SHORT, KIND_HEADER, '0, '0, 0, 1'b1));
            else
            begin
                ent = s*NRING + head_tab[s];
                n = len_mem[ent];
                if (n > PMAX)
                    n = PMAX;
                if (n > lim - HEADER_BYTES)
                    n = lim - HEADER_BYTES;
                expected_results.push_back(make_res(ST_OK, KIND_HEADER, sender_mem[ent], '0, n,
                                                    n == 0));
                for (int i = 0; i < n; i++)
                    expected_results.push_back(make_res(ST_OK, KIND_PAYLOAD, '0,
                                                        byte_mem[ent*PMAX + i], 0, i + 1 == n));
                head_tab[s] = (head_tab[s] + 1) % NRING;
                count_tab[s]--;
            end
        end
    endtask

    // Drives one word at the falling edge and holds it until the block takes it.
    task automatic send_word(cmd_t c);
        while ($urandom_range(99) < idle_pct)
        begin
            @(negedge clk);
        end
        start = 1'b1;
        cmd = c;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        route_word(c);
        @(negedge clk);
        start = 1'b0;
        cmd = rand_cmd();
    endtask

    function automatic cmd_t byte_word(logic [PID_W-1:0] own, logic [PID_W-1:0] tgt,
                                       logic [7:0] b, logic hb, logic lb);
        cmd_t c;
        c = rand_cmd();
        c.action = ACT_SEND;
        c.own_pid = own;
        c.dest_pid = tgt;
        c.data_byte = b;
        c.has_byte = hb;
        c.last_byte = lb;
        return c;
    endfunction

    function automatic cmd_t read_word(logic [PID_W-1:0] own, logic [7:0] lim);
        cmd_t c;
        c = rand_cmd();
        c.action = ACT_RECEIVE;
        c.own_pid = own;
        c.read_limit = lim;
        c.has_byte = 1'b0;
        c.last_byte = 1'b0;
        return c;
    endfunction

    task automatic send_packet(logic [PID_W-1:0] own, logic [PID_W-1:0] tgt, int nbytes);
        if (nbytes == 0)
            send_word(byte_word(own, tgt, 8'($urandom), 1'b0, 1'b1));
        for (int i = 0; i < nbytes; i++)
            send_word(byte_word(own, tgt, 8'($urandom), $urandom_range(9) != 0,
                                i == nbytes - 1));
    endtask

    task automatic wait_drained();
        while (expected_results.size() != 0 && !timed_out)
            @(posedge clk);
        repeat (60) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic test_directed();
        send_word(read_word(15'd0, 8'd255));
        send_packet(15'd7, 15'd0, 1);
        send_packet(15'd7, 15'd100, 2);
        send_word(read_word(15'd100, 8'd255));
        send_packet(15'h7FFF, 15'd100, 0);
        send_packet(15'd1, 15'd100, 40);
        send_word(byte_word(15'd2, 15'd100, 8'hFF, 1'b1, 1'b0));
        send_word(read_word(15'd100, 8'd3));
        send_word(byte_word(15'd2, 15'd100, 8'h00, 1'b1, 1'b1));
        send_word(read_word(15'd100, 8'd4));
        send_word(read_word(15'd100, 8'd255));
        send_word(read_word(15'd100, 8'd9));
        send_word(read_word(15'd100, 8'd9));
        for (int i = 0; i < 9; i++)
            send_packet(15'd5, 15'd100, 1);
        wait_drained();
        for (int i = 0; i < 7; i++)
            send_word(read_word(15'(32767 - i), 8'd8));
    endtask

    task automatic test_random();
        logic [PID_W-1:0] pool [8];
        int sent;
        int r;
        for (int i = 0; i < 8; i++)
            pool[i] = (i == 0) ? 15'd100 : 15'($urandom_range(32767, 1));
        for (int i = 0; i < 7; i++)
            pool[i+1] = owner_tab[i+1] != '0 ? owner_tab[i+1] : pool[i+1];
        sent = 0;
        while (sent < 360)
        begin
            if (sent == 180)
            begin
                idle_pct = 0;
                wait_drained();
            end
            if (sent == 250)
                idle_pct = 34;
            r = $urandom_range(99);
            if (r < 50)
            begin
                r = ($urandom_range(3) == 0) ? $urandom_range(PMAX + 4) : $urandom_range(6);
                send_packet(15'($urandom), pool[$urandom_range(7)], r);
                sent += (r == 0) ? 1 : r;
            end
            else if (r < 90)
            begin
                send_word(read_word(pool[$urandom_range(7)],
                                    8'(($urandom_range(3) == 0) ? $urandom
                                                                : $urandom_range(12))));
                sent++;
            end
            else
            begin
                send_word(byte_word(15'($urandom), 15'($urandom), 8'($urandom),
                                    1'($urandom), 1'($urandom)));
                sent++;
            end
        end
        send_word(byte_word(15'd3, 15'd100, 8'h5A, 1'b1, 1'b1));
    endtask

    always @(posedge clk)
    begin
        if (rst_n && strobe)
        begin
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word %p", result);
            end
            else if (result !== expected_results[0])
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %p, actual %p", expected_results[0], result);
                void'(expected_results.pop_front());
            end
            else
                void'(expected_results.pop_front());
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || strobe || (start && !busy) || (expected_results.size() == 0 && !start))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_LIMIT)
            timed_out <= 1'b1;
    end

    always @(posedge timed_out)
    begin
        $display("** pid_mailbox_packet_router: FAILED **");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        mismatches = 0;
        quiet_cycles = 0;
        timed_out = 1'b0;
        idle_pct = 34;
        pkt_open = 1'b0;
        pkt_err = ST_OK;
        pkt_fill = 0;
        pkt_slot = 0;
        for (int i = 0; i < NSLOT; i++)
        begin
            owner_tab[i] = '0;
            head_tab[i] = 0;
            tail_tab[i] = 0;
            count_tab[i] = 0;
        end
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_random();
        wait_drained();
        if (mismatches == 0 && expected_results.size() == 0)
            $display("** pid_mailbox_packet_router: PASSED **");
        else
            $display("** pid_mailbox_packet_router: FAILED **");
        $finish;
    end
endmodule
